// ===== rtl/mdic_pkg.sv =====
// Package for the decoded-instruction checker: mnemonic codes, addressing modes,
// mode class masks and the per-stage flag structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mdic_pkg;

	localparam logic [3:0] M_NONE   = 4'd0;
	localparam logic [3:0] M_DREG   = 4'd1;
	localparam logic [3:0] M_AREG   = 4'd2;
	localparam logic [3:0] M_AIND   = 4'd3;
	localparam logic [3:0] M_APOST  = 4'd4;
	localparam logic [3:0] M_APRE   = 4'd5;
	localparam logic [3:0] M_ADISP  = 4'd6;
	localparam logic [3:0] M_AINDEX = 4'd7;
	localparam logic [3:0] M_ABSW   = 4'd8;
	localparam logic [3:0] M_ABSL   = 4'd9;
	localparam logic [3:0] M_PCD    = 4'd10;
	localparam logic [3:0] M_PCX    = 4'd11;
	localparam logic [3:0] M_IMM    = 4'd12;

	localparam logic [15:0] CLS_CONTROL   = 16'h0FC8;
	localparam logic [15:0] CLS_MEMALT    = 16'h03F8;
	localparam logic [15:0] CLS_DATAALT   = 16'h03FA;
	localparam logic [15:0] CLS_DATA      = 16'h1FFA;
	localparam logic [15:0] CLS_QUICK     = 16'h03FE;
	localparam logic [15:0] CLS_MOVEM_R2M = 16'h03E8;
	localparam logic [15:0] CLS_MOVEM_M2R = 16'h0FD8;

	localparam logic [6:0] F_INVALID = 7'd0;
	localparam logic [6:0] F_UNKNOWN = 7'd1;
	localparam logic [6:0] F_NOP     = 7'd2;
	localparam logic [6:0] F_TRAPV   = 7'd7;
	localparam logic [6:0] F_ILLEGAL = 7'd8;
	localparam logic [6:0] F_STOP    = 7'd9;
	localparam logic [6:0] F_TRAP    = 7'd10;
	localparam logic [6:0] F_BRA     = 7'd11;
	localparam logic [6:0] F_BSR     = 7'd12;
	localparam logic [6:0] F_BCC     = 7'd13;
	localparam logic [6:0] F_JMP     = 7'd14;
	localparam logic [6:0] F_JSR     = 7'd15;
	localparam logic [6:0] F_PEA     = 7'd16;
	localparam logic [6:0] F_LEA     = 7'd17;
	localparam logic [6:0] F_MOVE    = 7'd18;
	localparam logic [6:0] F_MOVEA   = 7'd19;
	localparam logic [6:0] F_ADDA    = 7'd20;
	localparam logic [6:0] F_SUBA    = 7'd21;
	localparam logic [6:0] F_CMPA    = 7'd22;
	localparam logic [6:0] F_EXG     = 7'd23;
	localparam logic [6:0] F_MOVEUSP = 7'd24;
	localparam logic [6:0] F_LINK    = 7'd25;
	localparam logic [6:0] F_UNLK    = 7'd26;
	localparam logic [6:0] F_MOVEP   = 7'd27;
	localparam logic [6:0] F_MOVEM   = 7'd28;
	localparam logic [6:0] F_MOVESR  = 7'd29;
	localparam logic [6:0] F_MOVECCR = 7'd30;
	localparam logic [6:0] F_CLR     = 7'd31;
	localparam logic [6:0] F_NEG     = 7'd32;
	localparam logic [6:0] F_NEGX    = 7'd33;
	localparam logic [6:0] F_NOT     = 7'd34;
	localparam logic [6:0] F_NBCD    = 7'd35;
	localparam logic [6:0] F_TAS     = 7'd36;
	localparam logic [6:0] F_ADDI    = 7'd37;
	localparam logic [6:0] F_EORI    = 7'd41;
	localparam logic [6:0] F_ORICCR  = 7'd42;
	localparam logic [6:0] F_EORISR  = 7'd47;
	localparam logic [6:0] F_ADD     = 7'd48;
	localparam logic [6:0] F_SUB     = 7'd49;
	localparam logic [6:0] F_OR      = 7'd50;
	localparam logic [6:0] F_AND     = 7'd51;
	localparam logic [6:0] F_CMP     = 7'd52;
	localparam logic [6:0] F_CMPM    = 7'd53;
	localparam logic [6:0] F_EOR     = 7'd54;
	localparam logic [6:0] F_BTST    = 7'd55;
	localparam logic [6:0] F_BCHG    = 7'd56;
	localparam logic [6:0] F_BCLR    = 7'd57;
	localparam logic [6:0] F_BSET    = 7'd58;
	localparam logic [6:0] F_ADDQ    = 7'd59;
	localparam logic [6:0] F_SUBQ    = 7'd60;
	localparam logic [6:0] F_TST     = 7'd61;
	localparam logic [6:0] F_CMPI    = 7'd62;
	localparam logic [6:0] F_CHK     = 7'd63;
	localparam logic [6:0] F_DIVS    = 7'd67;
	localparam logic [6:0] F_EXT     = 7'd68;
	localparam logic [6:0] F_SWAP    = 7'd69;
	localparam logic [6:0] F_SCC     = 7'd70;
	localparam logic [6:0] F_DBCC    = 7'd71;
	localparam logic [6:0] F_ASL     = 7'd72;
	localparam logic [6:0] F_ROR     = 7'd79;
	localparam logic [6:0] F_ADDX    = 7'd80;
	localparam logic [6:0] F_SUBX    = 7'd81;
	localparam logic [6:0] F_ABCD    = 7'd82;
	localparam logic [6:0] F_SBCD    = 7'd83;
	localparam logic [6:0] F_MOVEQ   = 7'd84;

	// stage 1 flags: field compares
	typedef struct packed {
		logic [6:0] fn;
		logic [7:0] len;
		logic [7:0] cc;
		logic [3:0] sm;
		logic [3:0] dm;
		logic [7:0] sz;
		logic sz0, sz1, sz2, sz4, szok, szwl;
		logic imm0, imm1, imm_q, imm_b, imm_w, imm15, imm_ill;
		logic reg0, reg_lt8, cpy0, cpy_eq_sr, sr0, sr_lt8, dr_lt8;
		logic sr_eq_reg, dr_eq_reg;
		logic [15:0] sm_oh, dm_oh;
	} s1_t;

	// stage 2 flags: extension lengths and class hits
	typedef struct packed {
		s1_t  b;
		logic len_da_2, len_da_4;     // len == 2+e / 4+e for dst DATAALT operand
		logic da_ok;                  // dst in DATAALT with valid ext
		logic q_ok, q_len;            // quick dst operand
		logic etd_ok, etd_ok_a;       // ea-to-dreg source ok, without/with An
		logic dte_ma, dte_da;         // dreg-to-ea valid with len
		logic len_ws;                 // word_src_len
	} s2_t;

endpackage
`default_nettype wire

// ===== rtl/m68k_decoded_instruction_checker.sv =====
// Top level of the decoded 68000 instruction checker: three-stage pipeline.
// Depends on mdic_pkg and mdic_ext.
//
// channel | direction | signals
// input   | in        | in_valid, in_ready, func .. dst_register
// result  | out       | out_valid, out_ready, is_legal
//
// One word per cycle unless the result side stalls; three register stages. S1
// compares fields, S2 forms extension lengths and class hits, S3 picks by
// mnemonic. Reset clears the stage valid bits. On a stall, a stage advances
// only when it is empty or when the one after it moves.
`timescale 1ns / 1ps
`default_nettype none
module m68k_decoded_instruction_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [6:0] func,
	input  wire logic [7:0] op_size,
	input  wire logic [7:0] length_bytes,
	input  wire logic [31:0] imm_value,
	input  wire logic [7:0] main_register,
	input  wire logic [7:0] source_register_copy,
	input  wire logic [7:0] cond_code,
	input  wire logic [3:0] src_mode,
	input  wire logic [7:0] src_register,
	input  wire logic [3:0] dst_mode,
	input  wire logic [7:0] dst_register,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            is_legal
);
	import mdic_pkg::*;

	logic v_s1, v_s2, v_s3;
	s1_t  d_s1;
	s2_t  d_s2;
	logic legal_s3;
	logic adv1, adv2, adv3;

	assign adv3 = !v_s3 || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;
	assign out_valid = v_s3;
	assign is_legal = legal_s3;

	// stage 1
	s1_t n1;
	always_comb begin
		n1 = '0;
		n1.fn  = func;
		n1.len = length_bytes;
		n1.cc  = cond_code;
		n1.sm  = src_mode;
		n1.dm  = dst_mode;
		n1.sz  = op_size;
		n1.sz0 = op_size == 8'd0;
		n1.sz1 = op_size == 8'd1;
		n1.sz2 = op_size == 8'd2;
		n1.sz4 = op_size == 8'd4;
		n1.szok = n1.sz1 | n1.sz2 | n1.sz4;
		n1.szwl = n1.sz2 | n1.sz4;
		n1.imm0 = imm_value == 32'd0;
		n1.imm1 = imm_value == 32'd1;
		n1.imm_q = imm_value >= 32'd1 && imm_value <= 32'd8;
		n1.imm_b = imm_value <= 32'hFF;
		n1.imm_w = imm_value <= 32'hFFFF;
		n1.imm15 = imm_value <= 32'd15;
		n1.imm_ill = n1.imm0 || imm_value == 32'd10 || imm_value == 32'd11;
		n1.reg0 = main_register == 8'd0;
		n1.reg_lt8 = main_register < 8'd8;
		n1.cpy0 = source_register_copy == 8'd0;
		n1.cpy_eq_sr = source_register_copy == src_register;
		n1.sr0 = src_register == 8'd0;
		n1.sr_lt8 = src_register < 8'd8;
		n1.dr_lt8 = dst_register < 8'd8;
		n1.sr_eq_reg = src_register == main_register;
		n1.dr_eq_reg = dst_register == main_register;
		n1.sm_oh = 16'd1 << src_mode;
		n1.dm_oh = 16'd1 << dst_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			d_s1 <= n1;
		end
	end

	// stage 2
	logic da_ok, ma_ok, q_ok, sd_ok;
	logic [2:0] da_e, ma_e, q_e, sd_e;
	mdic_ext u_da (.mode_oh(d_s1.dm_oh), .reg_lt8(d_s1.dr_lt8), .sz4(d_s1.sz4),
		.szok(d_s1.szok), .mask(CLS_DATAALT), .ok(da_ok), .ext(da_e));
	mdic_ext u_ma (.mode_oh(d_s1.dm_oh), .reg_lt8(d_s1.dr_lt8), .sz4(d_s1.sz4),
		.szok(d_s1.szok), .mask(CLS_MEMALT), .ok(ma_ok), .ext(ma_e));
	mdic_ext u_q (.mode_oh(d_s1.dm_oh), .reg_lt8(d_s1.dr_lt8), .sz4(d_s1.sz4),
		.szok(d_s1.szok), .mask(CLS_QUICK), .ok(q_ok), .ext(q_e));
	mdic_ext u_sd (.mode_oh(d_s1.sm_oh), .reg_lt8(d_s1.sr_lt8), .sz4(d_s1.sz4),
		.szok(d_s1.szok), .mask(CLS_DATA), .ok(sd_ok), .ext(sd_e));

	s2_t n2;
	always_comb begin
		n2 = '0;
		n2.b = d_s1;
		n2.da_ok = da_ok;
		n2.len_da_2 = d_s1.len == 8'd2 + {5'd0, da_e};
		n2.len_da_4 = d_s1.len == 8'd4 + {5'd0, da_e};
		n2.q_ok = q_ok;
		n2.q_len = d_s1.len == 8'd2 + {5'd0, q_e};
		n2.etd_ok = sd_ok && d_s1.len == 8'd2 + {5'd0, sd_e};
		n2.etd_ok_a = d_s1.sm_oh[M_AREG] ? (!d_s1.sz1 && d_s1.sr_lt8 &&
			d_s1.len == 8'd2) : n2.etd_ok;
		n2.dte_ma = ma_ok && d_s1.len == 8'd2 + {5'd0, ma_e};
		n2.dte_da = da_ok && n2.len_da_2;
		if (d_s1.sm_oh[M_DREG] | d_s1.sm_oh[M_AIND] | d_s1.sm_oh[M_APOST] |
		    d_s1.sm_oh[M_APRE])
			n2.len_ws = d_s1.len == 8'd2;
		else if (d_s1.sm_oh[M_ADISP] | d_s1.sm_oh[M_AINDEX] | d_s1.sm_oh[M_ABSW] |
		    d_s1.sm_oh[M_PCD] | d_s1.sm_oh[M_PCX] | d_s1.sm_oh[M_IMM])
			n2.len_ws = d_s1.len == 8'd4;
		else if (d_s1.sm_oh[M_ABSL])
			n2.len_ws = d_s1.len == 8'd6;
		else
			n2.len_ws = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			d_s2 <= n2;
		end
	end

	// stage 3: select by mnemonic
	logic r;
	always_comb begin
		logic [6:0] f;
		logic l2b, l4b, l246, noea, smn, dmn, smd, dmd, sma, dma, cmpil, immw, extp;
		logic in_da_d, in_data_s, in_ctl_s, in_ma_d, in_da_s;
		logic etd, etda, dte_ma, dte_da, bitsz, bitdr, bitn;
		f = d_s2.b.fn;
		l2b = d_s2.b.len == 8'd2;
		l4b = d_s2.b.len == 8'd4;
		l246 = l2b || l4b || d_s2.b.len == 8'd6;
		smn = d_s2.b.sm == M_NONE;
		dmn = d_s2.b.dm == M_NONE;
		smd = d_s2.b.sm == M_DREG;
		dmd = d_s2.b.dm == M_DREG;
		sma = d_s2.b.sm == M_AREG;
		dma = d_s2.b.dm == M_AREG;
		noea = smn && dmn;
		extp = (smd && dmd) || (d_s2.b.sm == M_APRE && d_s2.b.dm == M_APRE);
		cmpil = d_s2.b.sz4 ? (d_s2.b.len == 8'd6 || d_s2.b.len == 8'd8 ||
			d_s2.b.len == 8'd10) : (l4b || d_s2.b.len == 8'd6 || d_s2.b.len == 8'd8);
		immw = d_s2.b.sz1 ? d_s2.b.imm_b : d_s2.b.sz2 ? d_s2.b.imm_w : d_s2.b.sz4;
		in_da_d = |(d_s2.b.dm_oh & CLS_DATAALT);
		in_ma_d = |(d_s2.b.dm_oh & CLS_MEMALT);
		in_data_s = |(d_s2.b.sm_oh & CLS_DATA);
		in_da_s = |(d_s2.b.sm_oh & CLS_DATAALT);
		in_ctl_s = |(d_s2.b.sm_oh & CLS_CONTROL);
		etd = d_s2.b.szok && d_s2.b.imm0 && d_s2.b.cpy_eq_sr && dmd && d_s2.b.dr_lt8;
		etda = etd && d_s2.etd_ok_a;
		etd = etd && d_s2.etd_ok;
		dte_ma = d_s2.b.szok && d_s2.b.imm0 && smd && d_s2.b.sr_lt8 &&
			d_s2.b.cpy_eq_sr && d_s2.dte_ma;
		dte_da = d_s2.b.szok && d_s2.b.imm0 && smd && d_s2.b.sr_lt8 &&
			d_s2.b.cpy_eq_sr && d_s2.dte_da;
		bitsz = d_s2.b.sz == (dmd ? 8'd4 : 8'd1);
		bitdr = d_s2.b.sr_lt8 && d_s2.b.cpy_eq_sr && d_s2.b.imm0 && d_s2.len_da_2;
		bitn = d_s2.b.sr0 && d_s2.b.cpy0 && d_s2.b.imm_b && d_s2.len_da_4;
		r = 1'b1;
		if (d_s2.b.len == 8'd0 || f <= F_UNKNOWN) begin
			r = 1'b0;
		end else if (f <= F_TRAPV) begin
			r = l2b && d_s2.b.sz0 && d_s2.b.imm0 && d_s2.b.reg0 && d_s2.b.cpy0 && noea;
		end else if (f >= F_ADDI && f <= F_EORI) begin
			r = d_s2.b.szok && cmpil && immw && d_s2.b.cpy0 && smn && in_da_d;
		end else if (f >= F_ORICCR && f <= F_EORISR) begin
			r = l4b && noea && (f[0] ? (d_s2.b.sz2 && d_s2.b.imm_w) :
				(d_s2.b.sz1 && d_s2.b.imm_b));
		end else if (f >= F_CHK && f <= F_DIVS) begin
			r = d_s2.b.sz2 && d_s2.len_ws && d_s2.b.imm0 && d_s2.b.cpy0 && in_data_s &&
				dmd && d_s2.b.dr_lt8;
		end else if (f >= F_ASL && f <= F_ROR) begin
			if (dmd)
				r = d_s2.b.szok && (smn ? d_s2.b.imm_q : smd);
			else
				r = smn && d_s2.b.sz2 && d_s2.b.imm1 && in_ma_d;
		end else begin
			case (f)
				F_ILLEGAL: r = l2b && d_s2.b.sz0 && d_s2.b.imm_ill && d_s2.b.reg0 &&
					d_s2.b.cpy0 && noea;
				F_STOP: r = l4b && d_s2.b.sz0 && d_s2.b.imm_w && noea;
				F_TRAP: r = l2b && d_s2.b.sz0 && d_s2.b.imm15 && noea;
				F_BRA, F_BSR, F_BCC: r = (l2b || l4b) && d_s2.b.sz0 && d_s2.b.imm0 &&
					d_s2.b.reg0 && d_s2.b.cpy0 && noea &&
					((f == F_BCC) ? (d_s2.b.cc >= 8'd2 && d_s2.b.cc <= 8'd15) :
					(d_s2.b.cc == 8'd0));
				F_JMP, F_JSR: r = dmn && in_ctl_s;
				F_PEA: r = d_s2.b.sz4 && dmn && in_ctl_s;
				F_LEA: r = d_s2.b.len >= 8'd2 && d_s2.b.sz4 && in_ctl_s && dma;
				F_MOVE: r = d_s2.b.szok && (sma ? !d_s2.b.sz1 : in_data_s) && in_da_d;
				F_MOVEA, F_ADDA, F_SUBA, F_CMPA: r = d_s2.b.szwl && l246 && d_s2.b.imm0 &&
					!smn && dma && d_s2.b.dr_lt8;
				F_EXG: r = d_s2.b.sz4 && ((smd && dmd) || (sma && dma) || (smd && dma));
				F_MOVEUSP: r = l2b && d_s2.b.sz4 && d_s2.b.reg_lt8 &&
					((sma && d_s2.b.sr_eq_reg && dmn) || (dma && d_s2.b.dr_eq_reg && smn));
				F_LINK: r = l4b && d_s2.b.reg_lt8 && noea;
				F_UNLK: r = l2b && d_s2.b.reg_lt8 && noea;
				F_MOVEP: r = d_s2.b.szwl && ((smd && d_s2.b.dm == M_ADISP) ||
					(d_s2.b.sm == M_ADISP && dmd));
				F_MOVEM: begin
					if (smn && !dmn) r = d_s2.b.szwl && |(d_s2.b.dm_oh & CLS_MOVEM_R2M);
					else if (dmn && !smn) r = d_s2.b.szwl && |(d_s2.b.sm_oh & CLS_MOVEM_M2R);
					else r = 1'b0;
				end
				F_MOVESR, F_MOVECCR: r = d_s2.b.sz2 && (!dmn ? in_da_d : in_data_s);
				F_CLR, F_NEG, F_NEGX, F_NOT: r = d_s2.b.szok && in_da_d;
				F_NBCD, F_TAS: r = d_s2.b.sz1 && in_da_d;
				F_ADD, F_SUB: r = dmd ? etda : dte_ma;
				F_OR, F_AND: r = dmd ? etd : dte_ma;
				F_CMP: r = etda;
				F_CMPM: r = d_s2.b.szok && d_s2.b.sm == M_APOST && d_s2.b.dm == M_APOST;
				F_EOR: r = dte_da;
				F_BTST: begin
					if (!smn && !smd) r = 1'b0;
					else if (dmd) r = d_s2.b.sz4;
					else r = d_s2.b.sz1 && |(d_s2.b.dm_oh & CLS_DATA) &&
						!(d_s2.b.dm == M_IMM && !smd);
				end
				F_BCHG, F_BCLR, F_BSET: r = d_s2.da_ok && bitsz &&
					(smd ? bitdr : (smn ? bitn : 1'b0));
				F_ADDQ, F_SUBQ: r = d_s2.b.imm_q && smn && d_s2.b.cpy0 && d_s2.q_ok &&
					d_s2.q_len && (dma ? d_s2.b.szwl : (d_s2.b.szok && in_da_d));
				F_TST: r = d_s2.b.szok && l246 && d_s2.b.imm0 && d_s2.b.cpy0 && dmn &&
					in_da_s;
				F_CMPI: r = d_s2.b.szok && cmpil && immw && d_s2.b.cpy0 && smn && in_da_d;
				F_EXT: r = l2b && d_s2.b.szwl && smn && dmd;
				F_SWAP: r = l2b && d_s2.b.sz4 && smn && dmd;
				F_SCC: r = l246 && d_s2.b.cc <= 8'd15 && d_s2.b.sz1 && d_s2.b.imm0 &&
					d_s2.b.reg0 && d_s2.b.cpy0 && smn && in_da_d;
				F_DBCC: r = l4b && d_s2.b.sz2 && d_s2.b.cc <= 8'd15 && d_s2.b.reg_lt8 &&
					d_s2.b.imm0 && d_s2.b.cpy0 && noea;
				F_ADDX, F_SUBX: r = d_s2.b.szok && extp;
				F_ABCD, F_SBCD: r = d_s2.b.sz1 && extp;
				F_MOVEQ: r = l2b && d_s2.b.sz4 && d_s2.b.reg_lt8 && noea;
				default: r = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			legal_s3 <= r;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mdic_ext.sv =====
// Extension length of one operand against a class mask; one-hot mode input.
// Depends on mdic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mdic_ext (
	input  wire logic [15:0] mode_oh,
	input  wire logic        reg_lt8,
	input  wire logic        sz4,
	input  wire logic        szok,
	input  wire logic [15:0] mask,
	output logic             ok,
	output logic [2:0]       ext
);
	import mdic_pkg::*;
	logic hit;
	always_comb begin
		hit = |(mode_oh & mask);
		ext = 3'd0;
		ok  = 1'b0;
		if (hit) begin
			if (mode_oh[M_DREG] | mode_oh[M_AREG] | mode_oh[M_AIND] |
			    mode_oh[M_APOST] | mode_oh[M_APRE]) begin
				ok = reg_lt8;
			end else if (mode_oh[M_ADISP] | mode_oh[M_AINDEX]) begin
				ok = reg_lt8; ext = 3'd2;
			end else if (mode_oh[M_ABSW] | mode_oh[M_PCD] | mode_oh[M_PCX]) begin
				ok = 1'b1; ext = 3'd2;
			end else if (mode_oh[M_ABSL]) begin
				ok = 1'b1; ext = 3'd4;
			end else if (mode_oh[M_IMM]) begin
				ok = szok; ext = sz4 ? 3'd4 : 3'd2;
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for m68k_decoded_instruction_checker: directed and random decoded
// instructions, legality predicted in-bench and checked in order. Uses mdic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import mdic_pkg::*;

	typedef struct {
		logic [6:0]  fn;
		logic [7:0]  sz, len;
		logic [31:0] imm;
		logic [7:0]  rg, cpy, cc;
		logic [3:0]  sm;
		logic [7:0]  sr;
		logic [3:0]  dm;
		logic [7:0]  dr;
	} insn_t;

	localparam int EXT_NONE = 255;

	function automatic bit in_class(logic [3:0] m, logic [15:0] mask);
		return mask[m];
	endfunction

	function automatic bit sz_any(int s);
		return s == 1 || s == 2 || s == 4;
	endfunction

	function automatic bit sz_wl(int s);
		return s == 2 || s == 4;
	endfunction

	function automatic bit len_246(int l);
		return l == 2 || l == 4 || l == 6;
	endfunction

	function automatic int ext_bytes(logic [3:0] m, int r, int s, logic [15:0] mask);
		if (!in_class(m, mask))
			return EXT_NONE;
		case (m)
			M_DREG, M_AREG, M_AIND, M_APOST, M_APRE: return r < 8 ? 0 : EXT_NONE;
			M_ADISP, M_AINDEX: return r < 8 ? 2 : EXT_NONE;
			M_ABSW, M_PCD, M_PCX: return 2;
			M_ABSL: return 4;
			M_IMM: begin
				if (!sz_any(s))
					return EXT_NONE;
				return s == 4 ? 4 : 2;
			end
			default: return EXT_NONE;
		endcase
	endfunction

	function automatic bit imm_fits(int s, logic [31:0] v);
		if (s == 1) return v <= 32'hFF;
		if (s == 2) return v <= 32'hFFFF;
		return s == 4;
	endfunction

	function automatic bit imm_len_ok(int s, int l);
		if (s == 4) return l == 6 || l == 8 || l == 10;
		return l == 4 || l == 6 || l == 8;
	endfunction

	function automatic bit word_src_len_ok(logic [3:0] m, int l);
		case (m)
			M_DREG, M_AIND, M_APOST, M_APRE: return l == 2;
			M_ADISP, M_AINDEX, M_ABSW, M_PCD, M_PCX, M_IMM: return l == 4;
			M_ABSL: return l == 6;
			default: return 0;
		endcase
	endfunction

	function automatic bit ea_into_dreg(insn_t x, bit an_ok);
		int e;
		if (an_ok && x.sm == M_AREG)
			e = (x.sz == 1 || x.sr >= 8) ? EXT_NONE : 0;
		else
			e = ext_bytes(x.sm, x.sr, x.sz, CLS_DATA);
		return sz_any(x.sz) && x.imm == 0 && x.cpy == x.sr && e != EXT_NONE &&
			x.dm == M_DREG && x.dr < 8 && x.len == 2 + e;
	endfunction

	function automatic bit dreg_into_ea(insn_t x, logic [15:0] mask);
		int e;
		e = ext_bytes(x.dm, x.dr, x.sz, mask);
		return sz_any(x.sz) && x.imm == 0 && x.sm == M_DREG && x.sr < 8 &&
			x.cpy == x.sr && e != EXT_NONE && x.len == 2 + e;
	endfunction

	function automatic bit legal_insn(insn_t x);
		int f, e;
		bit noea, pair;
		f = x.fn;
		noea = x.sm == M_NONE && x.dm == M_NONE;
		pair = (x.sm == M_DREG && x.dm == M_DREG) || (x.sm == M_APRE && x.dm == M_APRE);
		if (x.len == 0 || f <= F_UNKNOWN)
			return 0;
		if (f <= F_TRAPV)
			return x.len == 2 && x.sz == 0 && x.imm == 0 && x.rg == 0 && x.cpy == 0 && noea;
		if ((f >= F_ADDI && f <= F_EORI) || f == F_CMPI)
			return sz_any(x.sz) && imm_len_ok(x.sz, x.len) && imm_fits(x.sz, x.imm) &&
				x.cpy == 0 && x.sm == M_NONE && in_class(x.dm, CLS_DATAALT);
		if (f >= F_ORICCR && f <= F_EORISR) begin
			if (x.len != 4 || !noea)
				return 0;
			if (f % 2 == 0)
				return x.sz == 1 && x.imm <= 32'hFF;
			return x.sz == 2 && x.imm <= 32'hFFFF;
		end
		if (f >= F_CHK && f <= F_DIVS)
			return x.sz == 2 && word_src_len_ok(x.sm, x.len) && x.imm == 0 &&
				x.cpy == 0 && in_class(x.sm, CLS_DATA) && x.dm == M_DREG && x.dr < 8;
		if (f >= F_ASL && f <= F_ROR) begin
			if (x.dm == M_DREG) begin
				if (!sz_any(x.sz)) return 0;
				if (x.sm != M_NONE) return x.sm == M_DREG;
				return x.imm >= 1 && x.imm <= 8;
			end
			return x.sm == M_NONE && x.sz == 2 && x.imm == 1 && in_class(x.dm, CLS_MEMALT);
		end
		case (f)
			F_ILLEGAL: return x.len == 2 && x.sz == 0 &&
				(x.imm == 0 || x.imm == 10 || x.imm == 11) && x.rg == 0 && x.cpy == 0 && noea;
			F_STOP: return x.len == 4 && x.sz == 0 && x.imm <= 32'hFFFF && noea;
			F_TRAP: return x.len == 2 && x.sz == 0 && x.imm <= 15 && noea;
			F_BRA, F_BSR, F_BCC: begin
				if ((x.len != 2 && x.len != 4) || x.sz != 0 || x.imm != 0 || x.rg != 0 ||
						x.cpy != 0 || !noea)
					return 0;
				if (f == F_BCC) return x.cc >= 2 && x.cc <= 15;
				return x.cc == 0;
			end
			F_JMP, F_JSR: return x.dm == M_NONE && in_class(x.sm, CLS_CONTROL);
			F_PEA: return x.sz == 4 && x.dm == M_NONE && in_class(x.sm, CLS_CONTROL);
			F_LEA: return x.len >= 2 && x.sz == 4 && in_class(x.sm, CLS_CONTROL) &&
				x.dm == M_AREG;
			F_MOVE: return sz_any(x.sz) &&
				(x.sm == M_AREG ? x.sz != 1 : in_class(x.sm, CLS_DATA)) &&
				in_class(x.dm, CLS_DATAALT);
			F_MOVEA, F_ADDA, F_SUBA, F_CMPA: return sz_wl(x.sz) && len_246(x.len) &&
				x.imm == 0 && x.sm != M_NONE && x.dm == M_AREG && x.dr < 8;
			F_EXG: return x.sz == 4 && ((x.sm == M_DREG && x.dm == M_DREG) ||
				(x.sm == M_AREG && x.dm == M_AREG) || (x.sm == M_DREG && x.dm == M_AREG));
			F_MOVEUSP: begin
				if (x.len != 2 || x.sz != 4 || x.rg >= 8) return 0;
				return (x.sm == M_AREG && x.sr == x.rg && x.dm == M_NONE) ||
					(x.dm == M_AREG && x.dr == x.rg && x.sm == M_NONE);
			end
			F_LINK: return x.len == 4 && x.rg < 8 && noea;
			F_UNLK: return x.len == 2 && x.rg < 8 && noea;
			F_MOVEP: return sz_wl(x.sz) && ((x.sm == M_DREG && x.dm == M_ADISP) ||
				(x.sm == M_ADISP && x.dm == M_DREG));
			F_MOVEM: begin
				if (!sz_wl(x.sz)) return 0;
				if (x.sm == M_NONE && x.dm != M_NONE) return in_class(x.dm, CLS_MOVEM_R2M);
				if (x.dm == M_NONE && x.sm != M_NONE) return in_class(x.sm, CLS_MOVEM_M2R);
				return 0;
			end
			F_MOVESR, F_MOVECCR: begin
				if (x.dm != M_NONE) return x.sz == 2 && in_class(x.dm, CLS_DATAALT);
				return x.sz == 2 && in_class(x.sm, CLS_DATA);
			end
			F_CLR, F_NEG, F_NEGX, F_NOT: return sz_any(x.sz) && in_class(x.dm, CLS_DATAALT);
			F_NBCD, F_TAS: return x.sz == 1 && in_class(x.dm, CLS_DATAALT);
			F_ADD, F_SUB, F_OR, F_AND: begin
				if (x.dm == M_DREG) return ea_into_dreg(x, f == F_ADD || f == F_SUB);
				return dreg_into_ea(x, CLS_MEMALT);
			end
			F_CMP: return ea_into_dreg(x, 1);
			F_CMPM: return sz_any(x.sz) && x.sm == M_APOST && x.dm == M_APOST;
			F_EOR: return dreg_into_ea(x, CLS_DATAALT);
			F_BTST: begin
				if (x.sm != M_NONE && x.sm != M_DREG) return 0;
				if (x.dm == M_DREG) return x.sz == 4;
				if (x.sz != 1 || !in_class(x.dm, CLS_DATA)) return 0;
				return !(x.dm == M_IMM && x.sm != M_DREG);
			end
			F_BCHG, F_BCLR, F_BSET: begin
				e = ext_bytes(x.dm, x.dr, x.sz, CLS_DATAALT);
				if (e == EXT_NONE) return 0;
				if (x.sz != (x.dm == M_DREG ? 4 : 1)) return 0;
				if (x.sm == M_DREG)
					return x.sr < 8 && x.cpy == x.sr && x.imm == 0 && x.len == 2 + e;
				if (x.sm == M_NONE)
					return x.sr == 0 && x.cpy == 0 && x.imm <= 32'hFF && x.len == 4 + e;
				return 0;
			end
			F_ADDQ, F_SUBQ: begin
				if (x.imm < 1 || x.imm > 8 || x.sm != M_NONE || x.cpy != 0) return 0;
				e = ext_bytes(x.dm, x.dr, x.sz, CLS_QUICK);
				if (e == EXT_NONE) return 0;
				if (x.dm == M_AREG) return sz_wl(x.sz) && x.len == 2 + e;
				return sz_any(x.sz) && in_class(x.dm, CLS_DATAALT) && x.len == 2 + e;
			end
			F_TST: return sz_any(x.sz) && len_246(x.len) && x.imm == 0 && x.cpy == 0 &&
				x.dm == M_NONE && in_class(x.sm, CLS_DATAALT);
			F_EXT: return x.len == 2 && sz_wl(x.sz) && x.sm == M_NONE && x.dm == M_DREG;
			F_SWAP: return x.len == 2 && x.sz == 4 && x.sm == M_NONE && x.dm == M_DREG;
			F_SCC: return len_246(x.len) && x.cc <= 15 && x.sz == 1 && x.imm == 0 &&
				x.rg == 0 && x.cpy == 0 && x.sm == M_NONE && in_class(x.dm, CLS_DATAALT);
			F_DBCC: return x.len == 4 && x.sz == 2 && x.cc <= 15 && x.rg < 8 &&
				x.imm == 0 && x.cpy == 0 && noea;
			F_ADDX, F_SUBX: return sz_any(x.sz) && pair;
			F_ABCD, F_SBCD: return x.sz == 1 && pair;
			F_MOVEQ: return x.len == 2 && x.sz == 4 && x.rg < 8 && noea;
			default: return 1;
		endcase
	endfunction

	class legality_board;
		bit pending[$];
		int errors, checked, legal_seen;

		function void note_word(insn_t x);
			pending.push_back(legal_insn(x));
		endfunction

		function void check_word(logic got);
			bit want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word, is_legal=%b", $realtime, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got) legal_seen++;
			if (got !== want) begin
				$display("%0t: is_legal mismatch, expected %b actual %b", $realtime, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_ready = 0;
	logic in_ready, out_valid, is_legal;
	insn_t cur = '{default: '0};
	int send_idle = 0, recv_stall = 0, hold_off = 0, quiet = 0;
	bit stim_done = 0;
	legality_board board = new();

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	m68k_decoded_instruction_checker dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(cur.fn), .op_size(cur.sz), .length_bytes(cur.len), .imm_value(cur.imm),
		.main_register(cur.rg), .source_register_copy(cur.cpy), .cond_code(cur.cc),
		.src_mode(cur.sm), .src_register(cur.sr), .dst_mode(cur.dm), .dst_register(cur.dr),
		.out_valid(out_valid), .out_ready(out_ready), .is_legal(is_legal)
	);

	// result side: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_word(is_legal);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else
			out_ready <= arst_n && ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 5000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [7:0] pick_reg();
		case ($urandom_range(9))
			0: return 8'($urandom);
			1: return 8'hFF;
			2: return 8'd8;
			default: return 8'($urandom_range(7));
		endcase
	endfunction

	function automatic logic [31:0] pick_imm();
		case ($urandom_range(7))
			0: return $urandom;
			1: return 32'hFFFFFFFF;
			2: return $urandom_range(16'hFFFF);
			3: return $urandom_range(255);
			4: return 0;
			default: return $urandom_range(11);
		endcase
	endfunction

	// mostly plausible encodings; about one in eight fully random
	function automatic insn_t rand_insn();
		insn_t x;
		logic [7:0] sizes[4] = '{0, 1, 2, 4};
		x.fn = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(86));
		if ($urandom_range(7) == 0) begin
			x = '{7'($urandom), 8'($urandom), 8'($urandom), $urandom, 8'($urandom),
				8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom), 4'($urandom),
				8'($urandom)};
			return x;
		end
		x.sz = sizes[$urandom_range(3)];
		x.len = 8'(2 * $urandom_range(5));
		x.imm = pick_imm();
		x.rg = ($urandom_range(2) == 0) ? pick_reg() : 8'd0;
		x.sr = pick_reg();
		x.dr = pick_reg();
		x.cpy = ($urandom_range(2) == 0) ? x.sr : (($urandom_range(1)) ? 8'd0 : pick_reg());
		x.cc = ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(15));
		x.sm = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(12));
		x.dm = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(12));
		if ($urandom_range(2) == 0) x.sm = M_NONE;
		return x;
	endfunction

	task automatic send_word(insn_t x);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		cur <= x;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_word(x);
	endtask

	task automatic run_phase(int n, int si, int rs);
		send_idle = si;
		recv_stall = rs;
		repeat (n) send_word(rand_insn());
	endtask

	initial begin
		insn_t d;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: reserved codes, zero length, all-ones fields, nop, moveq, trap edges, illegal, addi, bcc, addq, add
		d = '{default: '0}; d.fn = F_INVALID; d.len = 2; send_word(d);
		d.fn = F_UNKNOWN; send_word(d);
		d.fn = F_NOP; d.len = 0; send_word(d);
		d.len = 2; send_word(d);
		d = '{7'h7F, 8'hFF, 8'hFF, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF, 4'hF, 8'hFF,
			4'hF, 8'hFF};
		send_word(d);
		d.fn = F_MOVE; send_word(d);
		d = '{default: '0}; d.fn = F_TRAP; d.len = 2; d.imm = 15; send_word(d);
		d.imm = 16; send_word(d);
		d.fn = F_ILLEGAL; d.imm = 11; send_word(d);
		d.fn = F_MOVEQ; d.imm = 0; d.sz = 4; send_word(d);
		d.sz = 3; send_word(d);
		d = '{default: '0}; d.fn = F_ADDI; d.sz = 1; d.len = 4; d.imm = 255;
		d.dm = M_DREG; send_word(d);
		d.imm = 256; send_word(d);
		d.dm = 4'd13; d.imm = 0; send_word(d);
		d = '{default: '0}; d.fn = F_BCC; d.len = 2; d.cc = 15; send_word(d);
		d.cc = 1; send_word(d);
		d = '{default: '0}; d.fn = F_ADDQ; d.sz = 2; d.len = 2; d.imm = 8;
		d.dm = M_AREG; send_word(d);
		d = '{default: '0}; d.fn = F_ADD; d.sz = 4; d.len = 6; d.sm = M_IMM;
		d.dm = M_DREG; send_word(d);
		// first code past the checked range
		d.fn = F_MOVEQ + 7'd1; send_word(d);
		d.fn = F_BSET; d.sz = 1; d.sm = M_NONE; d.dm = M_ABSL; d.len = 8; send_word(d);
		for (int f = F_NOP; f <= F_MOVEQ + 1; f++) begin
			d = rand_insn(); d.fn = 7'(f); send_word(d);
		end
		run_phase(450, 0, 0);
		run_phase(400, 54, 0);
		run_phase(400, 0, 54);
		// long receiver hold-off while words keep coming
		hold_off = 200;
		run_phase(100, 0, 0);
		run_phase(350, 21, 21);
		in_valid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d instruction words, %0d legal, across idle/stall mixes.",
			board.checked, board.legal_seen);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
